[rtl/three_button_debounce_double_press_macros.svh]
// Assertion macros for the three-button debouncer checker.
// Needs nothing but the clock and reset names that each use passes in.
`ifndef THREE_BUTTON_DEBOUNCE_DOUBLE_PRESS_MACROS_SVH
`define THREE_BUTTON_DEBOUNCE_DOUBLE_PRESS_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TBDP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbdp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TBDP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbdp assertion failed");

`endif

[rtl/tbdp_pkg.sv]
// Shared types and constants for the three-button debouncer.
// Used by the interfaces, the lanes, the merge stage, the top level and the checker.
package tbdp_pkg;

    localparam int TICK_W    = 32;
    localparam int CFG_W     = 16;
    localparam int ADDR_W    = 3;
    localparam int NUM_LANES = 3;

    localparam int LANE_UP   = 0;
    localparam int LANE_DOWN = 1;
    localparam int LANE_OK   = 2;

    localparam logic [CFG_W-1:0] LOCKOUT_RESET = 16'd30;
    localparam logic [CFG_W-1:0] WINDOW_RESET  = 16'd350;

    // Register index, taken from byte address bit 2.
    localparam logic REG_LOCKOUT = 1'b0;
    localparam logic REG_WINDOW  = 1'b1;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_UP        = 3'd1,
        EV_UP_DOUBLE = 3'd2,
        EV_DOWN      = 3'd3,
        EV_OK        = 3'd4
    } event_code_t;

    // What one debouncer lane found for the current poll.
    typedef struct packed {
        logic change;
        logic press;
    } lane_stat_t;

endpackage

[rtl/tbdp_poll_if.sv]
// Poll channel: three raw active-low button levels and the tick time.
// Depends on tbdp_pkg for the tick width.
interface tbdp_poll_if;
    import tbdp_pkg::*;

    logic              valid;
    logic              ready;
    logic              up_raw;
    logic              down_raw;
    logic              ok_raw;
    logic [TICK_W-1:0] now_ticks;

    modport source (output valid, output up_raw, output down_raw, output ok_raw,
                    output now_ticks, input ready);
    modport sink   (input valid, input up_raw, input down_raw, input ok_raw,
                    input now_ticks, output ready);
endinterface

[rtl/tbdp_event_if.sv]
// Event channel: one event code word per poll.
// Depends on tbdp_pkg for the event code type.
interface tbdp_event_if;
    import tbdp_pkg::*;

    logic        valid;
    logic        ready;
    event_code_t event_code;

    modport source (output valid, output event_code, input ready);
    modport sink   (input valid, input event_code, output ready);
endinterface

[rtl/three_button_debounce_double_press.sv]
// Top level of the three-button debouncer with double-press detection on up.
// Depends on tbdp_pkg, tbdp_poll_if, tbdp_event_if, tbdp_lane and tbdp_merge.
//
//  Channel  Direction  Handshake               Carries
//  poll     in         valid/ready             up_raw, down_raw, ok_raw, now_ticks
//  evt      out        valid/ready             event_code
//  APB      in         psel/penable, pready=1  lockout_ticks, double_window_ticks
//
// One poll is taken every cycle while poll.ready is high; its event word is registered
// in the output register, or in the skid register on a stall. The lanes and the merge
// compare are combinational, so the next poll sees the updated state with no bubble.
// When the event side stalls, a skid register holds one more word; poll.ready
// drops only once both the output register and the skid register are full.
// Reset (rst_n low, asynchronous) releases all buttons, clears all times and loads
// the register defaults; there is no clearing pass.
module three_button_debounce_double_press (
    input  logic                           clk,
    input  logic                           rst_n,
    tbdp_poll_if.sink                      poll,
    tbdp_event_if.source                   evt,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tbdp_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import tbdp_pkg::*;

    logic [CFG_W-1:0]       lockout_reg;
    logic [CFG_W-1:0]       lockout_next;
    logic [CFG_W-1:0]       window_reg;
    logic [CFG_W-1:0]       window_next;
    logic                   cfg_write;
    logic [NUM_LANES-1:0]   raw;
    logic [NUM_LANES-1:0]   commit;
    lane_stat_t [NUM_LANES-1:0] stat;

    // The configuration port never waits. Registers are decoded from address bit 2,
    // so the lockout sits at byte 0 and the double window at byte 4.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        lockout_next = lockout_reg;
        window_next  = window_reg;
        if (cfg_write)
        begin
            case (paddr[2])
                REG_LOCKOUT: lockout_next = pwdata[CFG_W-1:0];
                REG_WINDOW:  window_next  = pwdata[CFG_W-1:0];
                default:     lockout_next = lockout_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_LOCKOUT: prdata = {{(32-CFG_W){1'b0}}, lockout_reg};
            REG_WINDOW:  prdata = {{(32-CFG_W){1'b0}}, window_reg};
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lockout_reg <= LOCKOUT_RESET;
            window_reg  <= WINDOW_RESET;
        end
        else
        begin
            lockout_reg <= lockout_next;
            window_reg  <= window_next;
        end
    end

    // Each button gets its own debouncer lane; all three evaluate every poll in
    // parallel, and the merge stage decides which of them may commit.
    assign raw[LANE_UP]   = poll.up_raw;
    assign raw[LANE_DOWN] = poll.down_raw;
    assign raw[LANE_OK]   = poll.ok_raw;

    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        tbdp_lane u_lane (
            .clk           (clk),
            .rst_n         (rst_n),
            .raw           (raw[i]),
            .now_ticks     (poll.now_ticks),
            .lockout_ticks (lockout_reg),
            .commit        (commit[i]),
            .stat          (stat[i])
        );
    end

    // The merge stage applies the up, down, ok priority, times the double press
    // against the previous up press, and owns the output and skid registers.
    tbdp_merge u_merge (
        .clk                 (clk),
        .rst_n               (rst_n),
        .poll_valid          (poll.valid),
        .poll_ready          (poll.ready),
        .now_ticks           (poll.now_ticks),
        .double_window_ticks (window_reg),
        .stat                (stat),
        .commit              (commit),
        .evt                 (evt)
    );
endmodule

[rtl/tbdp_lane.sv]
// One debouncer lane: accepted level, time of last accepted change, lockout compare.
// Depends on tbdp_pkg.
module tbdp_lane (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           raw,
    input  logic [tbdp_pkg::TICK_W-1:0]    now_ticks,
    input  logic [tbdp_pkg::CFG_W-1:0]     lockout_ticks,
    input  logic                           commit,
    output tbdp_pkg::lane_stat_t           stat
);
    import tbdp_pkg::*;

    logic              level_reg;
    logic              level_next;
    logic [TICK_W-1:0] changed_at_reg;
    logic [TICK_W-1:0] changed_at_next;
    logic [TICK_W-1:0] elapsed;

    // Wrapping difference; a new level is taken only once the lockout has strictly passed.
    assign elapsed     = now_ticks - changed_at_reg;
    assign stat.change = (raw != level_reg) &&
                         (elapsed > {{(TICK_W-CFG_W){1'b0}}, lockout_ticks});
    assign stat.press  = stat.change && !raw;

    always_comb
    begin
        level_next      = level_reg;
        changed_at_next = changed_at_reg;
        if (commit && stat.change)
        begin
            level_next      = raw;
            changed_at_next = now_ticks;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg      <= 1'b1;
            changed_at_reg <= '0;
        end
        else
        begin
            level_reg      <= level_next;
            changed_at_reg <= changed_at_next;
        end
    end
endmodule

[rtl/tbdp_merge.sv]
// Merge stage: priority over the lanes, double-press timing, output register with skid.
// Depends on tbdp_pkg and tbdp_event_if.
module tbdp_merge (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          poll_valid,
    output logic                                          poll_ready,
    input  logic [tbdp_pkg::TICK_W-1:0]                   now_ticks,
    input  logic [tbdp_pkg::CFG_W-1:0]                    double_window_ticks,
    input  tbdp_pkg::lane_stat_t [tbdp_pkg::NUM_LANES-1:0] stat,
    output logic [tbdp_pkg::NUM_LANES-1:0]                commit,
    tbdp_event_if.source                                  evt
);
    import tbdp_pkg::*;

    logic              accept;
    logic [TICK_W-1:0] since;
    event_code_t       code;

    logic [TICK_W-1:0] last_press_reg;
    logic [TICK_W-1:0] last_press_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    event_code_t       out_code_reg;
    event_code_t       out_code_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    event_code_t       skid_code_reg;
    event_code_t       skid_code_next;

    assign poll_ready = !skid_valid_reg;
    assign accept     = poll_valid && poll_ready;
    assign since      = now_ticks - last_press_reg;

    // A lower lane commits its state only when no higher lane reported a press.
    assign commit[LANE_UP]   = accept;
    assign commit[LANE_DOWN] = accept && !stat[LANE_UP].press;
    assign commit[LANE_OK]   = accept && !stat[LANE_UP].press && !stat[LANE_DOWN].press;

    always_comb
    begin
        code            = EV_NONE;
        last_press_next = last_press_reg;
        if (stat[LANE_UP].press)
        begin
            code = (since < {{(TICK_W-CFG_W){1'b0}}, double_window_ticks}) ?
                   EV_UP_DOUBLE : EV_UP;
            if (accept)
            begin
                last_press_next = now_ticks;
            end
        end
        else if (stat[LANE_DOWN].press)
        begin
            code = EV_DOWN;
        end
        else if (stat[LANE_OK].press)
        begin
            code = EV_OK;
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_code_next   = out_code_reg;
        skid_valid_next = skid_valid_reg;
        skid_code_next  = skid_code_reg;
        if (!out_valid_reg || evt.ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_code_next   = skid_code_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = accept;
                out_code_next  = code;
            end
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
            skid_code_next  = code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_press_reg <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            last_press_reg <= last_press_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_code_reg  <= out_code_next;
        skid_code_reg <= skid_code_next;
    end

    assign evt.valid      = out_valid_reg;
    assign evt.event_code = out_code_reg;
endmodule

[rtl/tbdp_checker.sv]
// Port-level checker for the three-button debouncer, bound to the top level.
// Depends on tbdp_pkg and three_button_debounce_double_press_macros.svh.
`include "three_button_debounce_double_press_macros.svh"

module tbdp_checker (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    poll_valid,
    input logic                    poll_ready,
    input logic                    evt_valid,
    input logic                    evt_ready,
    input tbdp_pkg::event_code_t   evt_code
);
    import tbdp_pkg::*;

    // A stalled word stays on the port unchanged.
    `TBDP_ASSERT_NEXT(a_evt_hold, clk, rst_n, evt_valid && !evt_ready, evt_valid && $stable(evt_code))

    // Only defined event codes leave the block.
    `TBDP_ASSERT_NOW(a_evt_code, clk, rst_n, evt_valid, evt_code <= EV_OK)

    // Polls are held off only while a finished word is waiting on the output.
    `TBDP_ASSERT_NOW(a_stall_cause, clk, rst_n, !poll_ready, evt_valid)

    // With the output draining, the skid empties and polls are taken again next cycle.
    `TBDP_ASSERT_NEXT(a_ready_back, clk, rst_n, !poll_ready && evt_ready, poll_ready)

    // Every accepted poll leaves a word on the output in the next cycle, its own or one held by a stall.
    `TBDP_ASSERT_NEXT(a_poll_to_evt, clk, rst_n, poll_valid && poll_ready, evt_valid)
endmodule

bind three_button_debounce_double_press tbdp_checker u_tbdp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .poll_valid (poll.valid),
    .poll_ready (poll.ready),
    .evt_valid  (evt.valid),
    .evt_ready  (evt.ready),
    .evt_code   (evt.event_code)
);
